[src/tdxt_pkg.sv]
// types, constants and lookup tables shared by the tiled dxt1 decode unit
// depends on nothing; every other file of the block imports it
package tdxt_pkg;

  localparam int CfgW    = 11;
  localparam int CfgIdxW = 1;
  localparam int CoordW  = 13;
  localparam int ChanW   = 8;
  localparam int QDepth  = 2;

  localparam logic [CfgIdxW-1:0] CfgTilesAcross = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTilesDown   = 1'b1;

  typedef struct packed {
    logic [15:0] color0;
    logic [15:0] color1;
    logic [31:0] index_bits;
  } in_item_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic              last_of_block;
    logic              last_of_image;
  } out_item_t;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t [3:0]        pal;
    logic [31:0]       index_bits;
    logic [CoordW-1:0] base_x;
    logic [CoordW-1:0] base_y;
    logic              image_end;
  } entry_t;

  typedef logic [ChanW-1:0] lut5_t [32];
  typedef logic [ChanW-1:0] lut6_t [64];

  function automatic lut5_t gen_exp5();
    lut5_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = ChanW'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic lut6_t gen_exp6();
    lut6_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = ChanW'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam lut5_t Exp5Lut = gen_exp5();
  localparam lut6_t Exp6Lut = gen_exp6();

  // x / 3 for x up to 765 by reciprocal 683 / 2048
  function automatic logic [ChanW-1:0] div3(logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * 21'd683;
    return prod[18:11];
  endfunction

endpackage

[src/tdxt_front.sv]
// front end: takes compressed sub-blocks, tracks tile position, builds the palette
// one register stage feeding the entry queue; uses tdxt_pkg
module tdxt_front #(
  parameter int MAX_TILES_ACROSS = 1024,
  parameter int MAX_TILES_DOWN   = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tdxt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tdxt_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                           push_i,
  input  tdxt_pkg::in_item_t             item_i,
  output logic                           full_o,
  output logic                           q_push_o,
  output tdxt_pkg::entry_t               q_data_o,
  input  logic                           q_full_i
);
  import tdxt_pkg::*;

  localparam int AcrW = $clog2(MAX_TILES_ACROSS + 1);
  localparam int DnW  = $clog2(MAX_TILES_DOWN + 1);
  localparam int ColW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
  localparam int RowW = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;

  function automatic rgb_t expand(logic [15:0] c);
    rgb_t e;
    e.r = Exp5Lut[c[15:11]];
    e.g = Exp6Lut[c[10:5]];
    e.b = Exp5Lut[c[4:0]];
    return e;
  endfunction

  logic [AcrW-1:0] across_q;
  logic [DnW-1:0]  down_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [1:0]      sb_q, sb_d;
  logic            accept;
  logic            last_col, last_row;

  logic              s1_valid_q;
  rgb_t              e0_q, e1_q;
  logic              mode_q;
  logic [31:0]       bits_q;
  logic [CoordW-1:0] bx_q, by_q;
  logic              end_q;

  // configuration, clamped to the legal range on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= AcrW'(1);
      down_q   <= DnW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTilesAcross: begin
          if (cfg_wdata_i == '0) across_q <= AcrW'(1);
          else if (32'(cfg_wdata_i) > 32'(MAX_TILES_ACROSS)) across_q <= AcrW'(MAX_TILES_ACROSS);
          else across_q <= AcrW'(cfg_wdata_i);
        end
        CfgTilesDown: begin
          if (cfg_wdata_i == '0) down_q <= DnW'(1);
          else if (32'(cfg_wdata_i) > 32'(MAX_TILES_DOWN)) down_q <= DnW'(MAX_TILES_DOWN);
          else down_q <= DnW'(cfg_wdata_i);
        end
        default: ;
      endcase
    end
  end

  assign full_o   = s1_valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = s1_valid_q && !q_full_i;

  assign last_col = ((AcrW + 1)'(col_q) + 1'b1) >= {1'b0, across_q};
  assign last_row = ((DnW + 1)'(row_q) + 1'b1) >= {1'b0, down_q};

  // position advance
  always_comb begin
    sb_d  = sb_q + 2'd1;
    col_d = col_q;
    row_d = row_q;
    if (sb_q == 2'd3) begin
      if (!last_col) begin
        col_d = col_q + 1'b1;
      end else begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      sb_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        sb_q  <= sb_d;
      end
      s1_valid_q <= accept || (s1_valid_q && !q_push_o);
    end
  end

  // endpoint expansion stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      e0_q   <= expand(item_i.color0);
      e1_q   <= expand(item_i.color1);
      mode_q <= item_i.color0 > item_i.color1;
      bits_q <= item_i.index_bits;
      bx_q   <= CoordW'({col_q, sb_q[0], 2'b00});
      by_q   <= CoordW'({row_q, sb_q[1], 2'b00});
      end_q  <= (sb_q == 2'd3) && last_col && last_row;
    end
  end

  // blend stage, registered by the queue
  function automatic logic [ChanW-1:0] blend_a(logic [ChanW-1:0] a, logic [ChanW-1:0] b,
                                               logic mode);
    logic [9:0] s;
    logic [8:0] h;
    s = {a, 1'b0} + 10'(b);
    h = 9'(a) + 9'(b);
    return mode ? div3(s) : h[8:1];
  endfunction

  function automatic logic [ChanW-1:0] blend_b(logic [ChanW-1:0] a, logic [ChanW-1:0] b,
                                               logic mode);
    logic [9:0] s;
    s = 10'(a) + {b, 1'b0};
    return mode ? div3(s) : '0;
  endfunction

  always_comb begin
    q_data_o.pal[0]     = e0_q;
    q_data_o.pal[1]     = e1_q;
    q_data_o.pal[2].r   = blend_a(e0_q.r, e1_q.r, mode_q);
    q_data_o.pal[2].g   = blend_a(e0_q.g, e1_q.g, mode_q);
    q_data_o.pal[2].b   = blend_a(e0_q.b, e1_q.b, mode_q);
    q_data_o.pal[3].r   = blend_b(e0_q.r, e1_q.r, mode_q);
    q_data_o.pal[3].g   = blend_b(e0_q.g, e1_q.g, mode_q);
    q_data_o.pal[3].b   = blend_b(e0_q.b, e1_q.b, mode_q);
    q_data_o.index_bits = bits_q;
    q_data_o.base_x     = bx_q;
    q_data_o.base_y     = by_q;
    q_data_o.image_end  = end_q;
  end

endmodule

[src/tdxt_queue.sv]
// short queue of decoded sub-block entries between front and back end
// uses tdxt_pkg for the entry type and depth
module tdxt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tdxt_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output tdxt_pkg::entry_t data_o,
  output logic             empty_o
);
  import tdxt_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  entry_t          mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(QDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (32'(wr_q) == QDepth - 1) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (32'(rd_q) == QDepth - 1) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[src/tdxt_back.sv]
// back end: walks the sixteen pixels of a queued entry into the result register
// uses tdxt_pkg
module tdxt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdxt_pkg::entry_t    q_data_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tdxt_pkg::out_item_t result_o
);
  import tdxt_pkg::*;

  logic [3:0]  cnt_q;
  logic        out_valid_q;
  out_item_t   out_q, pix;
  logic        step;
  logic [31:0] sh;
  logic [1:0]  idx;

  assign step    = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = step && (cnt_q == 4'd15);
  assign empty_o = !out_valid_q;
  assign result_o = out_q;

  always_comb begin
    sh  = q_data_i.index_bits << {cnt_q, 1'b0};
    idx = sh[31:30];
    pix.pixel_x       = q_data_i.base_x + CoordW'(cnt_q[1:0]);
    pix.pixel_y       = q_data_i.base_y + CoordW'(cnt_q[3:2]);
    pix.red           = q_data_i.pal[idx].r;
    pix.green         = q_data_i.pal[idx].g;
    pix.blue          = q_data_i.pal[idx].b;
    pix.last_of_block = cnt_q == 4'd15;
    pix.last_of_image = (cnt_q == 4'd15) && q_data_i.image_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) cnt_q <= cnt_q + 4'd1;
      if (step) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= pix;
  end

endmodule

[src/tiled_dxt1_texture_decode_unit.sv]
// top level of the tiled dxt1 sub-block decoder
// instantiates tdxt_front, tdxt_queue and tdxt_back; uses tdxt_pkg
//
// Each request is one 8-byte dxt1 sub-block; it yields sixteen pixel results,
// row by row, with image coordinates from the tile position counters. The
// back end emits one pixel per cycle while the queue holds an entry and the
// result register is empty or being popped. The endpoint expansion is
// registered when the request is taken, the blends are written into a
// two-entry queue once it has room, and with an idle back end the first pixel
// then reaches the result register. full rises while the expansion register
// holds a request and the queue is full. Tile counts are clamped on write to
// 1..MAX; a register write takes effect at the next request. No clearing pass
// after reset.
module tiled_dxt1_texture_decode_unit #(
  parameter int MAX_TILES_ACROSS = 1024,
  parameter int MAX_TILES_DOWN   = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tdxt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tdxt_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         push,
  output logic                         full,
  input  tdxt_pkg::in_item_t           item_i,
  output logic                         empty,
  input  logic                         pop,
  output tdxt_pkg::out_item_t          result_o
);
  import tdxt_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  tdxt_front #(
    .MAX_TILES_ACROSS(MAX_TILES_ACROSS),
    .MAX_TILES_DOWN  (MAX_TILES_DOWN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .q_full_i   (q_full)
  );

  tdxt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  tdxt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_data_i (q_rdata),
    .q_empty_i(q_empty),
    .q_pop_o  (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result_o)
  );

endmodule
